[design/bpcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcs_pkg
// Shared types, widths, register indexes and reset values for the button
// press calibration sequencer.
// ----------------------------------------------------------------------------
package bpcs_pkg;

  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MS16_W   = 16;
  localparam int RPT_W    = 24;

  localparam int SAMPLE_BITS = 12;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  localparam logic [MS16_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [MS16_W-1:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [MS16_W-1:0] SHORT_MIN_RST  = 16'd50;
  localparam logic [RPT_W-1:0]  REPORT_RST     = 24'd30000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 3'd0,
    CFG_LONG_PRESS = 3'd1,
    CFG_SHORT_MIN  = 3'd2,
    CFG_REPORT     = 3'd3,
    CFG_PROVISION  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DRY  = 2'd1,
    PH_WET  = 2'd2,
    PH_SEND = 2'd3
  } phase_t;

endpackage

[design/bpcs_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcs_in_if
// Poll channel: timestamp, raw button level and sensor sample.
// ----------------------------------------------------------------------------
interface bpcs_in_if;
  logic                             valid;
  logic                             ready;
  logic [bpcs_pkg::TIME_W-1:0]      now_ms;
  logic                             button_level;
  logic [bpcs_pkg::SAMPLE_W-1:0]    sensor_sample;

  modport source (output valid, output now_ms, output button_level,
                  output sensor_sample, input ready);
  modport sink   (input valid, input now_ms, input button_level,
                  input sensor_sample, output ready);
endinterface

[design/bpcs_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcs_out_if
// Result channel: calibration phase, event flags and stored samples.
// ----------------------------------------------------------------------------
interface bpcs_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       calib_phase;
  logic                             short_press;
  logic                             long_press;
  logic                             calib_cancelled;
  logic                             calib_done;
  logic                             report_due;
  logic [bpcs_pkg::SAMPLE_W-1:0]    dry_level;
  logic [bpcs_pkg::SAMPLE_W-1:0]    wet_level;

  modport source (output valid, output calib_phase, output short_press,
                  output long_press, output calib_cancelled, output calib_done,
                  output report_due, output dry_level, output wet_level,
                  input ready);
  modport sink   (input valid, input calib_phase, input short_press,
                  input long_press, input calib_cancelled, input calib_done,
                  input report_due, input dry_level, input wet_level,
                  output ready);
endinterface

[design/button_press_calibration_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_calibration_sequencer
// Debounces a button, classifies releases as short or long presses and steps
// a dry/wet calibration sequence; raises a periodic report pulse while idle.
//
//   channel   direction  handshake      payload
//   in_bus    sink       valid/ready    now_ms, button_level, sensor_sample
//   out_bus   source     valid/ready    calib_phase, flags, dry/wet levels
//   cfg_*     sink       write enable   cfg_index, cfg_data
//
// One poll per cycle sustained while out_bus.ready holds; a poll passes the input
// register, then the result register after one pass of compare and phase logic.
// Synchronous reset clears both valid flags and all state, and presets config.
// A stalled result holds the result register; the input register keeps
// accepting as long as the result register can take its transaction.
// ----------------------------------------------------------------------------
module button_press_calibration_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  bpcs_in_if.sink                            in_bus,
  bpcs_out_if.source                         out_bus,
  input  logic                               cfg_we,
  input  logic [bpcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int TW = bpcs_pkg::TIME_W;
  localparam int SW = bpcs_pkg::SAMPLE_W;

  // configuration
  logic [bpcs_pkg::MS16_W-1:0] debounce_r, long_press_r, short_min_r;
  logic [bpcs_pkg::RPT_W-1:0]  report_int_r;
  logic                        provision_r;

  // input stage
  logic          s_valid_r;
  logic [TW-1:0] s_now_r;
  logic          s_level_r;
  logic [SW-1:0] s_sample_r;

  // block state
  logic               prev_level_r, prev_level_nxt;
  logic [TW-1:0]      change_time_r, change_time_nxt;
  logic               held_r, held_nxt;
  logic [TW-1:0]      press_start_r, press_start_nxt;
  bpcs_pkg::phase_t   phase_r, phase_nxt;
  logic [SW-1:0]      dry_r, dry_nxt;
  logic [SW-1:0]      wet_r, wet_nxt;
  logic [TW-1:0]      last_report_r, last_report_nxt;

  // result register
  logic               o_valid_r;
  logic [1:0]         o_phase_r;
  logic               o_short_r, o_long_r, o_cancel_r, o_done_r, o_report_r;
  logic [SW-1:0]      o_dry_r, o_wet_r;

  logic               f_short, f_long, f_cancel, f_done, f_report;
  logic               advance;
  logic [TW-1:0]      since_change, dur, since_report;
  logic               stable;

  assign advance      = !o_valid_r || out_bus.ready;
  assign in_bus.ready = !s_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= bpcs_pkg::DEBOUNCE_RST;
      long_press_r <= bpcs_pkg::LONG_PRESS_RST;
      short_min_r  <= bpcs_pkg::SHORT_MIN_RST;
      report_int_r <= bpcs_pkg::REPORT_RST;
      provision_r  <= 1'b0;
    end else if (cfg_we) begin
      case (bpcs_pkg::cfg_idx_t'(cfg_index))
        bpcs_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_data[bpcs_pkg::MS16_W-1:0];
        bpcs_pkg::CFG_LONG_PRESS: long_press_r <= cfg_data[bpcs_pkg::MS16_W-1:0];
        bpcs_pkg::CFG_SHORT_MIN:  short_min_r  <= cfg_data[bpcs_pkg::MS16_W-1:0];
        bpcs_pkg::CFG_REPORT:     report_int_r <= cfg_data[bpcs_pkg::RPT_W-1:0];
        bpcs_pkg::CFG_PROVISION:  provision_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s_now_r    <= in_bus.now_ms;
      s_level_r  <= in_bus.button_level;
      s_sample_r <= in_bus.sensor_sample;
    end
  end

  always_comb begin
    prev_level_nxt  = prev_level_r;
    change_time_nxt = change_time_r;
    held_nxt        = held_r;
    press_start_nxt = press_start_r;
    phase_nxt       = phase_r;
    dry_nxt         = dry_r;
    wet_nxt         = wet_r;
    last_report_nxt = last_report_r;
    f_short  = 1'b0;
    f_long   = 1'b0;
    f_cancel = 1'b0;
    f_done   = 1'b0;
    f_report = 1'b0;

    if (s_level_r != prev_level_r) begin
      change_time_nxt = s_now_r;
    end
    since_change = s_now_r - change_time_nxt;
    stable       = since_change > TW'(debounce_r);
    dur          = s_now_r - press_start_r;

    if (!provision_r) begin
      if (stable && (s_level_r == held_r)) begin
        if (!s_level_r) begin
          held_nxt        = 1'b1;
          press_start_nxt = s_now_r;
        end else begin
          held_nxt = 1'b0;
          if (dur > TW'(long_press_r)) begin
            f_long = 1'b1;
          end else if (dur > TW'(short_min_r)) begin
            f_short = 1'b1;
          end
        end
      end
      prev_level_nxt = s_level_r;

      if (f_long) begin
        if (phase_r == bpcs_pkg::PH_IDLE) begin
          phase_nxt = bpcs_pkg::PH_DRY;
        end else begin
          phase_nxt = bpcs_pkg::PH_IDLE;
          f_cancel  = 1'b1;
        end
      end else begin
        if (f_short) begin
          case (phase_r)
            bpcs_pkg::PH_DRY: begin
              dry_nxt   = s_sample_r & bpcs_pkg::SAMPLE_MASK;
              phase_nxt = bpcs_pkg::PH_WET;
            end
            bpcs_pkg::PH_WET: begin
              wet_nxt   = s_sample_r & bpcs_pkg::SAMPLE_MASK;
              phase_nxt = bpcs_pkg::PH_SEND;
            end
            bpcs_pkg::PH_SEND: begin
              f_done          = 1'b1;
              phase_nxt       = bpcs_pkg::PH_IDLE;
              last_report_nxt = s_now_r;
            end
            default: ;
          endcase
        end
        since_report = s_now_r - last_report_nxt;
        if ((phase_nxt == bpcs_pkg::PH_IDLE) && (since_report > TW'(report_int_r))) begin
          f_report        = 1'b1;
          last_report_nxt = s_now_r;
        end
      end
    end else begin
      change_time_nxt = change_time_r;
    end
    if (f_long || provision_r) begin
      since_report = '0;
    end else begin
      since_report = s_now_r - last_report_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= 1'b1;
      change_time_r <= '0;
      held_r        <= 1'b0;
      press_start_r <= '0;
      phase_r       <= bpcs_pkg::PH_IDLE;
      dry_r         <= '0;
      wet_r         <= '0;
      last_report_r <= '0;
    end else if (s_valid_r && advance) begin
      prev_level_r  <= prev_level_nxt;
      change_time_r <= change_time_nxt;
      held_r        <= held_nxt;
      press_start_r <= press_start_nxt;
      phase_r       <= phase_nxt;
      dry_r         <= dry_nxt;
      wet_r         <= wet_nxt;
      last_report_r <= last_report_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (advance) begin
      o_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid_r && advance) begin
      o_phase_r  <= phase_nxt;
      o_short_r  <= f_short;
      o_long_r   <= f_long;
      o_cancel_r <= f_cancel;
      o_done_r   <= f_done;
      o_report_r <= f_report;
      o_dry_r    <= dry_nxt;
      o_wet_r    <= wet_nxt;
    end
  end

  assign out_bus.valid           = o_valid_r;
  assign out_bus.calib_phase     = o_phase_r;
  assign out_bus.short_press     = o_short_r;
  assign out_bus.long_press      = o_long_r;
  assign out_bus.calib_cancelled = o_cancel_r;
  assign out_bus.calib_done      = o_done_r;
  assign out_bus.report_due      = o_report_r;
  assign out_bus.dry_level       = o_dry_r;
  assign out_bus.wet_level       = o_wet_r;

endmodule
